>>> rtl/core/pbfp_pkg.sv
// Shared types, constants and helper functions for the body frame projector.
// Used by the multiplier, divider, square root and top level; no dependencies.
package pbfp_pkg;

  localparam int MUL_W   = 33;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int NUM_W   = 54;
  localparam int DEN_W   = 48;
  localparam int RAD_W   = 62;
  localparam int ROOT_W  = 31;
  localparam int MAT_FRAC = 28;
  localparam int US_PER_S = 1000000;
  localparam int CFG_IDX_W = 3;

  localparam logic [1:0] OP_POSE = 2'd0;
  localparam logic [1:0] OP_ANG  = 2'd1;
  localparam logic [1:0] OP_LIN  = 2'd2;

  localparam logic [1:0] KIND_GRAV = 2'd0;
  localparam logic [1:0] KIND_LIN  = 2'd1;
  localparam logic [1:0] KIND_ANG  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_VEL_EN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VEL_TW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_EN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANG_EXT = 3'd3;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  // quaternion component pair per product: xx yy zz xy xz yz wx wy wz
  function automatic logic [3:0] prd_pair(input logic [3:0] idx);
    logic [3:0] r;
    case (idx)
      4'd0:    r = {2'd1, 2'd1};
      4'd1:    r = {2'd2, 2'd2};
      4'd2:    r = {2'd3, 2'd3};
      4'd3:    r = {2'd1, 2'd2};
      4'd4:    r = {2'd1, 2'd3};
      4'd5:    r = {2'd2, 2'd3};
      4'd6:    r = {2'd0, 2'd1};
      4'd7:    r = {2'd0, 2'd2};
      4'd8:    r = {2'd0, 2'd3};
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_ent(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd1073741824) begin
      r = 32'sd1073741824;
    end else if (v < -35'sd1073741824) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -38'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat_q16(input logic [NUM_W-1:0] quo, input logic neg);
    logic signed [15:0] r;
    logic signed [17:0] n;
    n = -$signed({1'b0, quo[16:0]});
    if (neg) begin
      r = (quo > NUM_W'(32768)) ? 16'sh8000 : n[15:0];
    end else begin
      r = (quo > NUM_W'(32767)) ? 16'sh7FFF : quo[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_v32(input logic [NUM_W-1:0] quo, input logic neg);
    logic signed [31:0] r;
    logic signed [33:0] n;
    n = -$signed({2'b0, quo[31:0]});
    if (neg) begin
      r = (quo > NUM_W'(64'h80000000)) ? 32'sh80000000 : n[31:0];
    end else begin
      r = (quo > NUM_W'(64'h7FFFFFFF)) ? 32'sh7FFFFFFF : quo[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/pbfp_mul.sv
// Shared signed multiplier with registered product.
// Depends on pbfp_pkg for operand widths.
module pbfp_mul (
  input  logic                               clk_i,
  input  logic signed [pbfp_pkg::MUL_W-1:0]  a_i,
  input  logic signed [pbfp_pkg::MUL_W-1:0]  b_i,
  output logic signed [pbfp_pkg::PROD_W-1:0] p_o
);

  logic signed [pbfp_pkg::PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

>>> rtl/core/pbfp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pbfp_pkg for widths and request/response types.
module pbfp_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbfp_pkg::div_req_t  req_i,
  output pbfp_pkg::div_rsp_t  rsp_o
);

  localparam int NW = pbfp_pkg::NUM_W;
  localparam int DW = pbfp_pkg::DEN_W;
  localparam int CW = $clog2(NW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] num_q, num_d;
  logic [DW-1:0] den_q, den_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [NW-1:0] quo_q, quo_d;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          ge;

  assign rem_sh  = {rem_q, num_q[NW-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.num;
      den_d  = req_i.den;
      rem_d  = '0;
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo_d = {quo_q[NW-2:0], ge};
      num_d = {num_q[NW-2:0], 1'b0};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

>>> rtl/core/pbfp_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on pbfp_pkg for widths and request/response types.
module pbfp_sqrt (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbfp_pkg::sqrt_req_t req_i,
  output pbfp_pkg::sqrt_rsp_t rsp_o
);

  localparam int RW = pbfp_pkg::RAD_W;
  localparam int OW = pbfp_pkg::ROOT_W;
  localparam int CW = $clog2(OW);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [RW-1:0] rad_q, rad_d;
  logic [OW:0]   rem_q, rem_d;
  logic [OW-1:0] root_q, root_d;
  logic [OW+2:0] rem_sh;
  logic [OW+2:0] trial;
  logic [OW+2:0] rem_sub;
  logic          ge;

  assign rem_sh  = {rem_q, rad_q[RW-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rad_d  = req_i.rad;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? rem_sub[OW:0] : rem_sh[OW:0];
      root_d = {root_q[OW-2:0], ge};
      rad_d  = {rad_q[RW-3:0], 2'b00};
      cnt_d  = cnt_q + CW'(1);
      if (cnt_q == CW'(OW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

>>> rtl/core/pose_body_frame_projector.sv
// Body frame projector: sequencer around one shared multiplier, divider and square root.
// The bit-serial divider (54 steps) serves both the quaternion normalisation and the velocity transfer.
// Throughput: one item at a time; in_stall_o stays high until the item's last result loads.
// Reset clears configuration to defaults, attitude and position become invalid.
// Depends on pbfp_pkg, pbfp_mul, pbfp_div and pbfp_sqrt.
module pose_body_frame_projector #(
  parameter int VEC_FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [pbfp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic                               cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         opcode_i,
  input  logic signed [15:0]                 quat_w_i,
  input  logic signed [15:0]                 quat_x_i,
  input  logic signed [15:0]                 quat_y_i,
  input  logic signed [15:0]                 quat_z_i,
  input  logic signed [31:0]                 pos_x_i,
  input  logic signed [31:0]                 pos_y_i,
  input  logic signed [31:0]                 pos_z_i,
  input  logic [47:0]                        stamp_us_i,
  input  logic signed [31:0]                 vec_x_i,
  input  logic signed [31:0]                 vec_y_i,
  input  logic signed [31:0]                 vec_z_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [1:0]                         kind_o,
  output logic signed [31:0]                 out_x_o,
  output logic signed [31:0]                 out_y_o,
  output logic signed [31:0]                 out_z_o,
  output logic                               last_o
);

  localparam int NW = pbfp_pkg::NUM_W;
  localparam int DW = pbfp_pkg::DEN_W;
  localparam int MW = pbfp_pkg::MUL_W;
  localparam int PW = pbfp_pkg::PROD_W;
  localparam int OW = pbfp_pkg::ROOT_W;
  localparam int FR = pbfp_pkg::MAT_FRAC;
  localparam logic signed [31:0] GRAV_Y = -(32'sd1 <<< VEC_FRAC_BITS);
  localparam logic signed [34:0] ONE_Q  = 35'sd1 <<< FR;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQ   = 4'd1;
  localparam logic [3:0] ST_SQRT = 4'd2;
  localparam logic [3:0] ST_NDIV = 4'd3;
  localparam logic [3:0] ST_PRD  = 4'd4;
  localparam logic [3:0] ST_MAT  = 4'd5;
  localparam logic [3:0] ST_ROT  = 4'd6;
  localparam logic [3:0] ST_EMIT = 4'd7;
  localparam logic [3:0] ST_VMUL = 4'd8;

  logic [3:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic [1:0] ph_q, ph_d;
  logic [1:0] ri_q, ri_d;
  logic [1:0] rj_q, rj_d;

  logic ven_q, ven_d, vtw_q, vtw_d, aen_q, aen_d, aext_q, aext_d;
  logic qv_q, qv_d, pv_q, pv_d;
  logic ov_q, ov_d;

  logic [1:0]         op_q, op_d;
  logic signed [15:0] qin_q [4];
  logic signed [15:0] qin_d [4];
  logic signed [31:0] pin_q [3];
  logic signed [31:0] pin_d [3];
  logic [47:0]        stamp_q, stamp_d;
  logic signed [31:0] rv_q [3];
  logic signed [31:0] rv_d [3];
  logic signed [63:0] acc_q, acc_d;
  logic [OW-1:0]      root_q, root_d;
  logic signed [15:0] nq_q [4];
  logic signed [15:0] nq_d [4];
  logic signed [31:0] prd_q [9];
  logic signed [31:0] prd_d [9];
  logic signed [31:0] mat_q [3][3];
  logic signed [31:0] mat_d [3][3];
  logic signed [31:0] o_q [3];
  logic signed [31:0] o_d [3];
  logic [1:0]         kind_q, kind_d;
  logic               last_q, last_d;
  logic               vact_q, vact_d;
  logic [47:0]        dt_q, dt_d;
  logic               vneg_q, vneg_d;
  logic signed [31:0] spos_q [3];
  logic signed [31:0] spos_d [3];
  logic [47:0]        sstamp_q, sstamp_d;
  logic [1:0]         okind_q, okind_d;
  logic signed [31:0] ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic               olast_q, olast_d;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  pbfp_pkg::div_req_t   div_req;
  pbfp_pkg::div_rsp_t   div_rsp;
  pbfp_pkg::sqrt_req_t  sqrt_req;
  pbfp_pkg::sqrt_rsp_t  sqrt_rsp;

  logic               in_xfer;
  logic               slot_free;
  logic [3:0]         pair;
  logic signed [32:0] dpos;
  logic [63:0]        acc_mag;
  logic [63:0]        acc_rnd;
  logic signed [37:0] rsig;
  logic signed [37:0] rneg;
  logic [PW-1:0]      prod_mag;
  logic signed [48:0] dts;
  logic signed [34:0] ent [3][3];
  logic               vout;

  pbfp_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  pbfp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  pbfp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  assign in_stall_o = state_q != ST_IDLE;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign slot_free  = !ov_q || !out_stall_i;
  assign pair       = pbfp_pkg::prd_pair(cnt_q);
  assign dpos       = 33'(pin_q[cnt_q[1:0]]) - 33'(spos_q[cnt_q[1:0]]);

  assign acc_mag = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
  assign acc_rnd = acc_mag + (64'd1 << (FR - 1));
  assign rsig    = acc_q[63] ? -$signed({2'b00, acc_rnd[63:FR]})
                             : $signed({2'b00, acc_rnd[63:FR]});
  assign rneg    = -rsig;

  assign prod_mag = prod[PW-1] ? PW'(-prod) : PW'(prod);
  assign dts      = $signed({1'b0, stamp_q}) - $signed({1'b0, sstamp_q});
  assign vout     = ven_q && !vtw_q && pv_q && (dts > 49'sd1);

  // rotation matrix entries in Q28 from the products xx yy zz xy xz yz wx wy wz
  always_comb begin
    ent[0][0] = ONE_Q - ((35'(prd_q[1]) + 35'(prd_q[2])) <<< 1);
    ent[0][1] = (35'(prd_q[3]) - 35'(prd_q[8])) <<< 1;
    ent[0][2] = (35'(prd_q[4]) + 35'(prd_q[7])) <<< 1;
    ent[1][0] = (35'(prd_q[3]) + 35'(prd_q[8])) <<< 1;
    ent[1][1] = ONE_Q - ((35'(prd_q[0]) + 35'(prd_q[2])) <<< 1);
    ent[1][2] = (35'(prd_q[5]) - 35'(prd_q[6])) <<< 1;
    ent[2][0] = (35'(prd_q[4]) - 35'(prd_q[7])) <<< 1;
    ent[2][1] = (35'(prd_q[5]) + 35'(prd_q[6])) <<< 1;
    ent[2][2] = ONE_Q - ((35'(prd_q[0]) + 35'(prd_q[1])) <<< 1);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ: begin
        mul_a = MW'(qin_q[cnt_q[1:0]]);
        mul_b = MW'(qin_q[cnt_q[1:0]]);
      end
      ST_PRD: begin
        mul_a = MW'(nq_q[pair[3:2]]);
        mul_b = MW'(nq_q[pair[1:0]]);
      end
      ST_ROT: begin
        mul_a = MW'(mat_q[rj_q][ri_q]);
        mul_b = MW'(rv_q[rj_q]);
      end
      ST_VMUL: begin
        mul_a = dpos;
        mul_b = MW'(pbfp_pkg::US_PER_S);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ph_d     = ph_q;
    ri_d     = ri_q;
    rj_d     = rj_q;
    ven_d    = ven_q;
    vtw_d    = vtw_q;
    aen_d    = aen_q;
    aext_d   = aext_q;
    qv_d     = qv_q;
    pv_d     = pv_q;
    ov_d     = ov_q && out_stall_i;
    op_d     = op_q;
    qin_d    = qin_q;
    pin_d    = pin_q;
    stamp_d  = stamp_q;
    rv_d     = rv_q;
    acc_d    = acc_q;
    root_d   = root_q;
    nq_d     = nq_q;
    prd_d    = prd_q;
    mat_d    = mat_q;
    o_d      = o_q;
    kind_d   = kind_q;
    last_d   = last_q;
    vact_d   = vact_q;
    dt_d     = dt_q;
    vneg_d   = vneg_q;
    spos_d   = spos_q;
    sstamp_d = sstamp_q;
    okind_d  = okind_q;
    ox_d     = ox_q;
    oy_d     = oy_q;
    oz_d     = oz_q;
    olast_d  = olast_q;
    div_req  = '0;
    sqrt_req = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        pbfp_pkg::CFG_VEL_EN:  ven_d  = cfg_wdata_i;
        pbfp_pkg::CFG_VEL_TW:  vtw_d  = cfg_wdata_i;
        pbfp_pkg::CFG_ANG_EN:  aen_d  = cfg_wdata_i;
        pbfp_pkg::CFG_ANG_EXT: aext_d = cfg_wdata_i;
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_d     = opcode_i;
          qin_d[0] = quat_w_i;
          qin_d[1] = quat_x_i;
          qin_d[2] = quat_y_i;
          qin_d[3] = quat_z_i;
          pin_d[0] = pos_x_i;
          pin_d[1] = pos_y_i;
          pin_d[2] = pos_z_i;
          stamp_d  = stamp_us_i;
          cnt_d    = '0;
          ph_d     = '0;
          ri_d     = '0;
          rj_d     = '0;
          acc_d    = '0;
          rv_d[0]  = vec_x_i;
          rv_d[1]  = vec_y_i;
          rv_d[2]  = vec_z_i;
          last_d   = 1'b1;
          if (opcode_i == pbfp_pkg::OP_POSE) begin
            state_d = ST_SQ;
          end else if (opcode_i == pbfp_pkg::OP_ANG) begin
            kind_d = pbfp_pkg::KIND_ANG;
            if (qv_q && aen_q && aext_q) state_d = ST_ROT;
          end else if (opcode_i == pbfp_pkg::OP_LIN) begin
            kind_d = pbfp_pkg::KIND_LIN;
            if (qv_q && ven_q && vtw_q) state_d = ST_ROT;
          end
        end
      end

      ST_SQ: begin
        if (cnt_q != 4'd0) acc_d = acc_q + prod[63:0];
        if (cnt_q == 4'd4) begin
          state_d = ST_SQRT;
          ph_d    = '0;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end

      ST_SQRT: begin
        if (ph_q == 2'd0) begin
          sqrt_req.start = 1'b1;
          sqrt_req.rad   = {1'b0, acc_q[32:0], {FR{1'b0}}};
          ph_d           = 2'd1;
        end else if (sqrt_rsp.done) begin
          root_d  = sqrt_rsp.root;
          state_d = ST_NDIV;
          cnt_d   = '0;
          ph_d    = '0;
        end
      end

      ST_NDIV: begin
        if (ph_q == 2'd0 && root_q != '0) begin
          div_req.start = 1'b1;
          div_req.num   = NW'({qin_q[cnt_q[1:0]][15] ? 17'(-qin_q[cnt_q[1:0]])
                                                     : 17'(qin_q[cnt_q[1:0]]),
                               {FR{1'b0}}}) + NW'(root_q >> 1);
          div_req.den   = DW'(root_q);
          ph_d          = 2'd1;
        end else if (ph_q == 2'd0 || div_rsp.done) begin
          nq_d[cnt_q[1:0]] = (root_q == '0) ? 16'sd0
                           : pbfp_pkg::sat_q16(div_rsp.quo, qin_q[cnt_q[1:0]][15]);
          ph_d = '0;
          if (cnt_q == 4'd3) begin
            state_d = ST_PRD;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
      end

      ST_PRD: begin
        if (cnt_q != 4'd0) prd_d[cnt_q - 4'd1] = prod[31:0];
        if (cnt_q == 4'd9) begin
          state_d = ST_MAT;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end

      ST_MAT: begin
        for (int r = 0; r < 3; r++) begin
          for (int c = 0; c < 3; c++) begin
            mat_d[r][c] = pbfp_pkg::clamp_ent(ent[r][c]);
          end
        end
        qv_d    = 1'b1;
        rv_d[0] = '0;
        rv_d[1] = GRAV_Y;
        rv_d[2] = '0;
        kind_d  = pbfp_pkg::KIND_GRAV;
        vact_d  = ven_q && !vtw_q;
        last_d  = !vout;
        dt_d    = dts[47:0];
        state_d = ST_ROT;
        ri_d    = '0;
        rj_d    = '0;
        ph_d    = '0;
      end

      ST_ROT: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else if (ph_q == 2'd1) begin
          acc_d = ((rj_q == 2'd0) ? 64'sd0 : acc_q) + prod[63:0];
          if (rj_q == 2'd2) begin
            ph_d = 2'd2;
          end else begin
            rj_d = rj_q + 2'd1;
            ph_d = 2'd0;
          end
        end else begin
          case (ri_q)
            2'd0:    o_d[0] = pbfp_pkg::sat32(rsig);
            2'd1:    o_d[2] = pbfp_pkg::sat32(rsig);
            default: o_d[1] = pbfp_pkg::sat32(rneg);
          endcase
          rj_d = '0;
          ph_d = '0;
          if (ri_q == 2'd2) begin
            state_d = ST_EMIT;
          end else begin
            ri_d = ri_q + 2'd1;
          end
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          ov_d    = 1'b1;
          okind_d = kind_q;
          ox_d    = o_q[0];
          oy_d    = o_q[1];
          oz_d    = o_q[2];
          olast_d = last_q;
          cnt_d   = '0;
          ph_d    = '0;
          if (!last_q) begin
            state_d = ST_VMUL;
          end else begin
            if (op_q == pbfp_pkg::OP_POSE && vact_q) begin
              spos_d   = pin_q;
              sstamp_d = stamp_q;
              pv_d     = 1'b1;
            end
            state_d = ST_IDLE;
          end
        end
      end

      ST_VMUL: begin
        if (ph_q == 2'd0) begin
          ph_d = 2'd1;
        end else if (ph_q == 2'd1) begin
          div_req.start = 1'b1;
          div_req.num   = prod_mag[NW-1:0] + NW'(dt_q >> 1);
          div_req.den   = dt_q;
          vneg_d        = prod[PW-1];
          ph_d          = 2'd2;
        end else if (div_rsp.done) begin
          rv_d[cnt_q[1:0]] = pbfp_pkg::sat_v32(div_rsp.quo, vneg_q);
          ph_d = '0;
          if (cnt_q == 4'd2) begin
            state_d = ST_ROT;
            kind_d  = pbfp_pkg::KIND_LIN;
            last_d  = 1'b1;
            ri_d    = '0;
            rj_d    = '0;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ph_q    <= '0;
      ri_q    <= '0;
      rj_q    <= '0;
      ven_q   <= 1'b0;
      vtw_q   <= 1'b0;
      aen_q   <= 1'b0;
      aext_q  <= 1'b1;
      qv_q    <= 1'b0;
      pv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ph_q    <= ph_d;
      ri_q    <= ri_d;
      rj_q    <= rj_d;
      ven_q   <= ven_d;
      vtw_q   <= vtw_d;
      aen_q   <= aen_d;
      aext_q  <= aext_d;
      qv_q    <= qv_d;
      pv_q    <= pv_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    qin_q    <= qin_d;
    pin_q    <= pin_d;
    stamp_q  <= stamp_d;
    rv_q     <= rv_d;
    acc_q    <= acc_d;
    root_q   <= root_d;
    nq_q     <= nq_d;
    prd_q    <= prd_d;
    mat_q    <= mat_d;
    o_q      <= o_d;
    kind_q   <= kind_d;
    last_q   <= last_d;
    vact_q   <= vact_d;
    dt_q     <= dt_d;
    vneg_q   <= vneg_d;
    spos_q   <= spos_d;
    sstamp_q <= sstamp_d;
    okind_q  <= okind_d;
    ox_q     <= ox_d;
    oy_q     <= oy_d;
    oz_q     <= oz_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o = ov_q;
  assign kind_o      = okind_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign out_z_o     = oz_q;
  assign last_o      = olast_q;

endmodule

>>> rtl/core/pbfp_chk.sv
// Port-level checker for the body frame projector, bound to the top level.
// Depends on pbfp_pkg for result kind codes.
module pbfp_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         kind_o,
  input logic signed [31:0] out_x_o,
  input logic signed [31:0] out_y_o,
  input logic signed [31:0] out_z_o,
  input logic               last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(out_x_o)
      && $stable(out_y_o) && $stable(out_z_o) && $stable(last_o))
    else $error("stalled result changed");

  a_nonlast_grav: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> kind_o == pbfp_pkg::KIND_GRAV)
    else $error("non-final result is not gravity");

  a_nonlast_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input taken while velocity result pending");

  a_ang_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == pbfp_pkg::KIND_ANG |-> last_o)
    else $error("angular result not final");

endmodule

bind pose_body_frame_projector pbfp_chk u_pbfp_chk (.*);

>>> dv/pose_body_frame_projector_tb.sv
// Self-checking testbench for pose_body_frame_projector: directed and random items
// with a scoreboard class that predicts gravity, body velocity and rotated vector transfers.
// Depends on pbfp_pkg and the pose_body_frame_projector RTL.
module pose_body_frame_projector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VFB = 16;
  localparam longint LIMIT_CYCLES = 4000000;
  localparam int SETTLE_CYCLES = 700;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]         op;
    logic signed [15:0] q[4];
    logic signed [31:0] p[3];
    logic [47:0]        st;
    logic signed [31:0] v[3];
  } item_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               last;
  } body_res_t;

  class projector_scoreboard;
    bit vel_en, vel_tw, ang_en, ang_ext;
    logic signed [15:0] att[4];
    bit att_ok;
    logic signed [31:0] last_pos[3];
    logic [47:0] last_stamp;
    bit pos_ok;
    body_res_t expected_q[$];
    int mismatches;

    function new();
      vel_en = 0; vel_tw = 0; ang_en = 0; ang_ext = 1;
      att_ok = 0; pos_ok = 0; mismatches = 0;
    endfunction

    function void set_reg(logic [pbfp_pkg::CFG_IDX_W-1:0] idx, bit val);
      case (idx)
        pbfp_pkg::CFG_VEL_EN:  vel_en = val;
        pbfp_pkg::CFG_VEL_TW:  vel_tw = val;
        pbfp_pkg::CFG_ANG_EN:  ang_en = val;
        pbfp_pkg::CFG_ANG_EXT: ang_ext = val;
        default: ;
      endcase
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(0) - v : v;
    endfunction

    function longint clampl(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint div_rnd(longint num, longint unsigned den);
      longint unsigned q;
      q = (mag(num) + den / 2) / den;
      return num < 0 ? -longint'(q) : longint'(q);
    endfunction

    function longint shr_rnd(longint v);
      longint unsigned q;
      q = (mag(v) + (64'd1 << (pbfp_pkg::MAT_FRAC - 1))) >> pbfp_pkg::MAT_FRAC;
      return v < 0 ? -longint'(q) : longint'(q);
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function string res_str(body_res_t r);
      return $sformatf("kind=%0d x=%0d y=%0d z=%0d last=%0b", r.kind, r.x, r.y, r.z, r.last);
    endfunction

    function body_res_t rotate(logic [1:0] kind, longint vin[3], logic lst);
      longint w, x, y, z, one, acc;
      longint m[3][3];
      longint b[3];
      body_res_t r;
      w = att[0]; x = att[1]; y = att[2]; z = att[3];
      one = 64'sd1 << pbfp_pkg::MAT_FRAC;
      m[0][0] = one - 2 * (y * y + z * z); m[0][1] = 2 * (x * y - w * z);
      m[0][2] = 2 * (x * z + w * y);       m[1][0] = 2 * (x * y + w * z);
      m[1][1] = one - 2 * (x * x + z * z); m[1][2] = 2 * (y * z - w * x);
      m[2][0] = 2 * (x * z - w * y);       m[2][1] = 2 * (y * z + w * x);
      m[2][2] = one - 2 * (x * x + y * y);
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int j = 0; j < 3; j++)
          acc += clampl(m[j][i], -(64'sd1 << 30), 64'sd1 << 30) * vin[j];
        b[i] = shr_rnd(acc);
      end
      r.kind = kind;
      r.x = 32'(clampl(b[0], -64'sd2147483648, 64'sd2147483647));
      r.y = 32'(clampl(-b[2], -64'sd2147483648, 64'sd2147483647));
      r.z = 32'(clampl(b[1], -64'sd2147483648, 64'sd2147483647));
      r.last = lst;
      return r;
    endfunction

    function void note_input(item_t it);
      longint unsigned n2, s;
      longint qv, dt, d;
      longint vw[3];
      body_res_t grav, vel;
      bit vel_out;
      vel_out = 0;
      if (it.op == pbfp_pkg::OP_POSE) begin
        n2 = 0;
        for (int i = 0; i < 4; i++) begin
          qv = it.q[i];
          n2 += qv * qv;
        end
        s = int_sqrt(n2 << pbfp_pkg::MAT_FRAC);
        for (int i = 0; i < 4; i++) begin
          qv = it.q[i];
          att[i] = (s != 0)
                 ? 16'(clampl(div_rnd(qv <<< pbfp_pkg::MAT_FRAC, s), -32768, 32767))
                 : 16'sd0;
        end
        att_ok = 1;
        vw[0] = 0; vw[1] = -(64'sd1 << VFB); vw[2] = 0;
        grav = rotate(pbfp_pkg::KIND_GRAV, vw, 1'b1);
        if (vel_en && !vel_tw) begin
          if (pos_ok) begin
            dt = longint'(it.st) - longint'(last_stamp);
            if (dt > 1) begin
              for (int i = 0; i < 3; i++) begin
                d = longint'(it.p[i]) - longint'(last_pos[i]);
                vw[i] = clampl(div_rnd(d * pbfp_pkg::US_PER_S, dt),
                               -64'sd2147483648, 64'sd2147483647);
              end
              vel = rotate(pbfp_pkg::KIND_LIN, vw, 1'b1);
              vel_out = 1;
            end
          end
          last_pos = it.p;
          last_stamp = it.st;
          pos_ok = 1;
        end
        grav.last = !vel_out;
        expected_q.push_back(grav);
        if (vel_out) expected_q.push_back(vel);
      end else if (it.op == pbfp_pkg::OP_ANG || it.op == pbfp_pkg::OP_LIN) begin
        if (att_ok && (it.op == pbfp_pkg::OP_ANG ? (ang_en && ang_ext)
                                                 : (vel_en && vel_tw))) begin
          for (int i = 0; i < 3; i++) vw[i] = it.v[i];
          expected_q.push_back(rotate(it.op == pbfp_pkg::OP_ANG ? pbfp_pkg::KIND_ANG
                                                                : pbfp_pkg::KIND_LIN,
                                      vw, 1'b1));
        end
      end
    endfunction

    function void check(body_res_t act);
      body_res_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer %s", res_str(act));
        return;
      end
      e = expected_q.pop_front();
      if (e.kind !== act.kind || e.x !== act.x || e.y !== act.y || e.z !== act.z ||
          e.last !== act.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch exp %s act %s", res_str(e), res_str(act));
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [pbfp_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic cfg_wdata_i = 0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic [1:0] opcode_i = '0;
  logic signed [15:0] quat_w_i = '0, quat_x_i = '0, quat_y_i = '0, quat_z_i = '0;
  logic signed [31:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [47:0] stamp_us_i = '0;
  logic signed [31:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic [1:0] kind_o;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic last_o;

  projector_scoreboard sb = new();
  longint cycles = 0;
  int stall_left = 0;
  logic [47:0] stamp_now = 48'd1000;
  logic signed [31:0] pos_now[3] = '{0, 0, 0};

  pose_body_frame_projector #(.VEC_FRAC_BITS(VFB)) dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("pose_body_frame_projector_tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i)
      sb.check('{kind_o, out_x_o, out_y_o, out_z_o, last_o});
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 2) == 0);
      stall_left <= rand_gap();
    end
  end

  task automatic write_reg(logic [pbfp_pkg::CFG_IDX_W-1:0] idx, bit val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic apply_cfg(bit ve, bit vt, bit ae, bit ax);
    write_reg(pbfp_pkg::CFG_VEL_EN, ve);
    write_reg(pbfp_pkg::CFG_VEL_TW, vt);
    write_reg(pbfp_pkg::CFG_ANG_EN, ae);
    write_reg(pbfp_pkg::CFG_ANG_EXT, ax);
  endtask

  task automatic send_item(item_t it, int gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= it.op;
    {quat_w_i, quat_x_i, quat_y_i, quat_z_i} <= {it.q[0], it.q[1], it.q[2], it.q[3]};
    {pos_x_i, pos_y_i, pos_z_i} <= {it.p[0], it.p[1], it.p[2]};
    stamp_us_i <= it.st;
    {vec_x_i, vec_y_i, vec_z_i} <= {it.v[0], it.v[1], it.v[2]};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic item_t mk(logic [1:0] op, logic signed [15:0] w, logic signed [15:0] x,
                               logic signed [15:0] y, logic signed [15:0] z,
                               logic signed [31:0] p, logic [47:0] st, logic signed [31:0] v);
    item_t it;
    it.op = op;
    it.q = '{w, x, y, z};
    it.p = '{p, -p, p};
    it.st = st;
    it.v = '{v, -v, 32'sd1 <<< VFB};
    return it;
  endfunction

  function automatic item_t rand_item();
    item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.op = r < 45 ? pbfp_pkg::OP_POSE
          : (r < 70 ? pbfp_pkg::OP_ANG : (r < 95 ? pbfp_pkg::OP_LIN : OP_UNUSED));
    for (int i = 0; i < 4; i++) it.q[i] = 16'($urandom);
    if ($urandom_range(0, 9) == 0) it.q[$urandom_range(0, 3)] = 0;
    r = $urandom_range(0, 99);
    if (r < 80) stamp_now = stamp_now + $urandom_range(2, 40000);
    else if (r < 90) stamp_now = stamp_now + $urandom_range(0, 1);
    else if (r < 95) stamp_now = stamp_now - $urandom_range(0, 5000);
    else stamp_now = 48'({$urandom, $urandom});
    it.st = stamp_now;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(0, 9) == 0) pos_now[i] = $urandom;
      else pos_now[i] = pos_now[i] + $signed($urandom_range(0, 8000)) - 4000;
      it.p[i] = pos_now[i];
      it.v[i] = $urandom_range(0, 3) == 0 ? $urandom
              : $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    end
    return it;
  endfunction

  initial begin
    item_t dir[$];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    apply_cfg(1, 1, 1, 1);
    for (int i = 4; i < 8; i++) write_reg(pbfp_pkg::CFG_IDX_W'(i), 0);
    dir.push_back(mk(pbfp_pkg::OP_ANG, 0, 0, 0, 0, 0, 0, 32'sd12345));
    dir.push_back(mk(pbfp_pkg::OP_LIN, 0, 0, 0, 0, 0, 0, 32'sd12345));
    dir.push_back(mk(pbfp_pkg::OP_POSE, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(pbfp_pkg::OP_ANG, 0, 0, 0, 0, 0, 0, 32'sh7FFFFFFF));
    dir.push_back(mk(pbfp_pkg::OP_LIN, 0, 0, 0, 0, 0, 0, 32'sh80000000));
    dir.push_back(mk(pbfp_pkg::OP_POSE, 16384, 0, 0, 0, 0, 0, 0));
    dir.push_back(mk(pbfp_pkg::OP_POSE, -32768, -32768, -32768, -32768, 0, 0, 0));
    dir.push_back(mk(pbfp_pkg::OP_ANG, 0, 0, 0, 0, 0, 0, 32'sh80000000));
    dir.push_back(mk(pbfp_pkg::OP_POSE, 32767, 32767, 32767, 32767, 0, 0, 0));
    dir.push_back(mk(pbfp_pkg::OP_LIN, 0, 0, 0, 0, 0, 0, 32'sh7FFFFFFF));
    dir.push_back(mk(pbfp_pkg::OP_POSE, 0, 1, 0, 0, 0, 0, 0));
    dir.push_back(mk(pbfp_pkg::OP_ANG, 0, 0, 0, 0, 0, 0, -32'sd1));
    dir.push_back(mk(OP_UNUSED, 1, 2, 3, 4, 5, 6, 7));
    foreach (dir[i]) send_item(dir[i], rand_gap());
    drain();

    apply_cfg(1, 0, 0, 0);
    dir.delete();
    dir.push_back(mk(pbfp_pkg::OP_POSE, 16384, 100, -200, 300, 32'sh7FFFFFFF, 48'd100, 0));
    dir.push_back(mk(pbfp_pkg::OP_POSE, 16384, 0, 0, 0, 32'sh80000000, 48'd102, 0));
    dir.push_back(mk(pbfp_pkg::OP_POSE, 16384, 0, 0, 0, 32'sd1000, 48'd103, 0));
    dir.push_back(mk(pbfp_pkg::OP_POSE, 16384, 0, 0, 0, 32'sd2000, 48'd103, 0));
    dir.push_back(mk(pbfp_pkg::OP_POSE, 16384, 0, 0, 0, 32'sd3000, 48'd50, 0));
    dir.push_back(mk(pbfp_pkg::OP_POSE, 0, 16384, 0, 0, 32'sd70000, 48'hFFFFFFFFFFFF, 0));
    dir.push_back(mk(pbfp_pkg::OP_POSE, 0, 0, 16384, 0, -32'sd70000, 48'd0, 0));
    dir.push_back(mk(pbfp_pkg::OP_POSE, 0, 0, 0, 0, 32'sd5, 48'd2, 0));
    dir.push_back(mk(pbfp_pkg::OP_LIN, 0, 0, 0, 0, 0, 0, 32'sd99));
    dir.push_back(mk(pbfp_pkg::OP_ANG, 0, 0, 0, 0, 0, 0, 32'sd99));
    foreach (dir[i]) send_item(dir[i], rand_gap());
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) apply_cfg(1, 0, 1, 1);
      else if (ph == 1) apply_cfg(1, 1, 1, 1);
      else if (ph == 2) apply_cfg(0, 0, 0, 0);
      else apply_cfg($urandom_range(0, 3) != 0, $urandom_range(0, 1),
                     $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0);
      for (int n = 0; n < 150; n++) send_item(rand_item(), ph == 5 ? 0 : rand_gap());
      drain();
    end

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("pose_body_frame_projector_tb passed");
    end else begin
      $display("pose_body_frame_projector_tb failed");
    end
    $finish;
  end
endmodule
